// ----- design/text_mode_console_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Text mode console engine assertion macros
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_ENGINE_MACROS_SVH
`define TEXT_MODE_CONSOLE_ENGINE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define TMCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define TMCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tmce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine package
// Command and result types, character codes and fixed constants.
// ----------------------------------------------------------------------------
package tmce_pkg;

    // Port field types
    typedef logic [1:0]  op_t;
    typedef logic [7:0]  char_t;
    typedef logic [10:0] idx_port_t;
    typedef logic [6:0]  col_port_t;
    typedef logic [4:0]  row_port_t;
    typedef logic [15:0] cell_t;
    typedef logic [7:0]  attr_t;

    // Operation codes
    localparam op_t OP_PUT   = 2'd0;
    localparam op_t OP_CLEAR = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    // Control characters and printable range
    localparam char_t CHAR_BS    = 8'h08;
    localparam char_t CHAR_TAB   = 8'h09;
    localparam char_t CHAR_LF    = 8'h0A;
    localparam char_t CHAR_CR    = 8'h0D;
    localparam char_t CHAR_SPACE = 8'h20;

    // Blank cell and attribute reset value
    localparam cell_t BLANK_CELL = 16'h0F20;
    localparam attr_t ATTR_RESET = 8'h0F;

    // Classified command kinds
    typedef enum logic [2:0] {
        K_PRINT,
        K_BS,
        K_TAB,
        K_CR,
        K_LF,
        K_NOP,
        K_CLEAR,
        K_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        char_t     char_code;
        idx_port_t cell_index;
    } cmd_t;

    typedef struct packed {
        col_port_t cursor_col;
        row_port_t cursor_row;
        idx_port_t cursor_location;
        logic      cell_written;
        idx_port_t write_index;
        cell_t     cell_data;
        logic      scrolled;
    } res_t;

endpackage

// ----- design/tmce_front.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine front end
// Accepts items and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module tmce_front (
    input  logic                start,
    input  tmce_pkg::op_t       op,
    input  tmce_pkg::char_t     char_code,
    input  tmce_pkg::idx_port_t cell_index,
    input  logic                q_full,
    input  logic                init_busy,
    output logic                busy,
    output logic                push,
    output tmce_pkg::cmd_t      push_cmd
);

    tmce_pkg::cmd_kind_t kind;

    // Hold off items while the queue is full or the store is being cleared
    assign busy = q_full || init_busy;
    assign push = start && !busy;

    // Classify the operation and character byte
    always_comb
    begin
        kind = tmce_pkg::K_NOP;
        unique case (op)
            tmce_pkg::OP_PUT:
            begin
                if (char_code == tmce_pkg::CHAR_BS)
                    kind = tmce_pkg::K_BS;
                else if (char_code == tmce_pkg::CHAR_TAB)
                    kind = tmce_pkg::K_TAB;
                else if (char_code == tmce_pkg::CHAR_CR)
                    kind = tmce_pkg::K_CR;
                else if (char_code == tmce_pkg::CHAR_LF)
                    kind = tmce_pkg::K_LF;
                else if (char_code >= tmce_pkg::CHAR_SPACE && !char_code[7])
                    kind = tmce_pkg::K_PRINT;
                else
                    kind = tmce_pkg::K_NOP;
            end
            tmce_pkg::OP_CLEAR: kind = tmce_pkg::K_CLEAR;
            tmce_pkg::OP_READ:  kind = tmce_pkg::K_READ;
            default:            kind = tmce_pkg::K_NOP;
        endcase
    end

    assign push_cmd.kind       = kind;
    assign push_cmd.char_code  = char_code;
    assign push_cmd.cell_index = cell_index;

endmodule

// ----- design/tmce_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tmce_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmce_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tmce_pkg::cmd_t pop_cmd,
    output logic           empty
);

    tmce_pkg::cmd_t entries_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entries_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- design/tmce_back.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine back end
// Cell store, cursor, clear and scroll sweeps and result register.
// ----------------------------------------------------------------------------
module tmce_back #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tmce_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    input  tmce_pkg::attr_t text_attribute,
    output logic            init_busy,
    output logic            done,
    output tmce_pkg::res_t  res
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int RW1        = RW + 1;
    localparam int NCW        = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int NSTOP      = (COLUMNS - 1) / TAB_WIDTH;
    localparam int SW         = $clog2(NSTOP + 2);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(COPY_CELLS - 1);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RESP   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_BLANK  = 3'd5;

    // Control registers
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              done_reg, done_next;

    // Payload registers
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              written_reg;
    logic [ADDR_W-1:0] windex_reg;
    tmce_pkg::cell_t   data_reg;
    logic              scrolled_reg;
    logic              use_q_reg;
    tmce_pkg::res_t    res_reg;

    // Cell store
    tmce_pkg::cell_t   mem [CELLS];
    tmce_pkg::cell_t   mem_q;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    tmce_pkg::cell_t   mem_wdata;

    // Cursor step
    logic [NCW-1:0]    col_ext, tab_col, cand_col;
    logic [SW-1:0]     stop_idx;
    logic              row_inc;
    logic [RW1-1:0]    row_sum;
    logic [CW-1:0]     new_col;
    logic [RW-1:0]     new_row;
    logic              new_scroll;
    logic [ADDR_W-1:0] windex;
    logic              rd_hit;
    logic              load_pend;
    tmce_pkg::cell_t   put_data;

    assign windex   = ADDR_W'(int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
    assign rd_hit   = int'(q_cmd.cell_index) < CELLS;
    assign put_data = {text_attribute, q_cmd.char_code};

    // Work out the cursor after the head command
    always_comb
    begin
        col_ext  = NCW'(cur_col_reg);
        stop_idx = '0;
        for (int k = 1; k <= NSTOP; k++)
        begin
            if (col_ext >= NCW'(k * TAB_WIDTH))
                stop_idx = SW'(k);
        end
        tab_col = NCW'((int'(stop_idx) + 1) * TAB_WIDTH);

        row_inc = 1'b0;
        case (q_cmd.kind)
            tmce_pkg::K_PRINT: cand_col = col_ext + NCW'(1);
            tmce_pkg::K_BS:    cand_col = (col_ext == '0) ? '0 : col_ext - NCW'(1);
            tmce_pkg::K_TAB:   cand_col = tab_col;
            tmce_pkg::K_CR:    cand_col = '0;
            tmce_pkg::K_LF:
            begin
                cand_col = '0;
                row_inc  = 1'b1;
            end
            default:           cand_col = col_ext;
        endcase

        // Wrap past the last column
        if (cand_col >= NCW'(COLUMNS))
        begin
            cand_col = '0;
            row_inc  = 1'b1;
        end

        // Scroll past the last row
        row_sum    = RW1'(cur_row_reg) + RW1'(row_inc);
        new_scroll = (row_sum == RW1'(ROWS));
        new_row    = new_scroll ? RW'(ROWS - 1) : RW'(row_sum);
        new_col    = CW'(cand_col);
    end

    // Sequencer: dispatch, sweeps and response
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        pend_valid_next = 1'b0;
        done_next       = 1'b0;
        q_pop           = 1'b0;
        load_pend       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = tmce_pkg::BLANK_CELL;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    load_pend    = 1'b1;
                    cur_col_next = new_col;
                    cur_row_next = new_row;
                    if (q_cmd.kind == tmce_pkg::K_PRINT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = windex;
                        mem_wdata = put_data;
                    end
                    if (q_cmd.kind == tmce_pkg::K_READ && rd_hit)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(q_cmd.cell_index);
                    end
                    if (q_cmd.kind == tmce_pkg::K_CLEAR)
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        ptr_next     = '0;
                        state_next   = S_CLEAR;
                    end
                    else if (new_scroll)
                    begin
                        ptr_next   = '0;
                        state_next = S_SCROLL;
                    end
                    else
                        state_next = S_RESP;
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_RESP;
                end
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end
            S_SCROLL:
            begin
                // Read one row ahead, write the cell fetched last cycle
                mem_re          = 1'b1;
                mem_raddr       = ptr_reg + ADDR_W'(COLUMNS);
                pend_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_q;
                end
                if (ptr_reg == LAST_COPY)
                begin
                    ptr_next   = ADDR_W'(COPY_CELLS);
                    state_next = S_BLANK;
                end
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end
            S_BLANK:
            begin
                mem_we = 1'b1;
                if (pend_valid_reg)
                begin
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_q;
                end
                else if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = S_RESP;
                end
                else
                    ptr_next = ptr_reg + ADDR_W'(1);
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ptr_reg        <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    // Cell store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // Capture command outcome and build the result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCROLL)
            pend_addr_reg <= ptr_reg;
        if (load_pend)
        begin
            written_reg  <= (q_cmd.kind == tmce_pkg::K_PRINT);
            windex_reg   <= (q_cmd.kind == tmce_pkg::K_PRINT) ? windex : '0;
            data_reg     <= (q_cmd.kind == tmce_pkg::K_PRINT) ? put_data : '0;
            scrolled_reg <= new_scroll;
            use_q_reg    <= (q_cmd.kind == tmce_pkg::K_READ) && rd_hit;
        end
        if (state_reg == S_RESP)
        begin
            res_reg.cursor_col      <= tmce_pkg::col_port_t'(cur_col_reg);
            res_reg.cursor_row      <= tmce_pkg::row_port_t'(cur_row_reg);
            res_reg.cursor_location <= tmce_pkg::idx_port_t'(
                int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
            res_reg.cell_written    <= written_reg;
            res_reg.write_index     <= tmce_pkg::idx_port_t'(windex_reg);
            res_reg.cell_data       <= use_q_reg ? mem_q : data_reg;
            res_reg.scrolled        <= scrolled_reg;
        end
    end

    assign init_busy = (state_reg == S_INIT);
    assign done      = done_reg;
    assign res       = res_reg;

endmodule

// ----- design/text_mode_console_engine.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine
// Character cell console with cursor, clear, scroll and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (op, char_code, cell_index) is taken at a rising
//   edge with start high and busy low. A two-entry queue sits between the
//   classifying front end and the executing back end, so busy rises only
//   when that queue is full or the clearing pass after reset is running.
//   Result channel: done is high for one cycle with the cursor, the stored or
//   read cell and the scroll flag; the receiver cannot stall it.
//   Configuration: cfg_wr_en writes cfg_wr_data into the text attribute.
//   Flow: a taken item waits in the queue until the idle back end pops it in
//   its dispatch state; the respond state then loads the result and raises done.
//   Back end: a put, control character or read passes through the dispatch and
//   respond states while the queue takes further items until full. A clear
//   blanks every cell in a sweep before responding; a put that scrolls adds a
//   copy-up and blanking sweep.
//   Reset: the cursor goes home, the attribute returns to 0x0F and a clearing
//   pass over all COLUMNS*ROWS cells (2000 by default) blanks the store while
//   busy stays high; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module text_mode_console_engine #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tmce_pkg::op_t       op,
    input  tmce_pkg::char_t     char_code,
    input  tmce_pkg::idx_port_t cell_index,
    input  logic                cfg_wr_en,
    input  tmce_pkg::attr_t     cfg_wr_data,
    output logic                done,
    output tmce_pkg::col_port_t cursor_col,
    output tmce_pkg::row_port_t cursor_row,
    output tmce_pkg::idx_port_t cursor_location,
    output logic                cell_written,
    output tmce_pkg::idx_port_t write_index,
    output tmce_pkg::cell_t     cell_data,
    output logic                scrolled
);

    tmce_pkg::attr_t text_attribute_reg;
    tmce_pkg::cmd_t  push_cmd, pop_cmd;
    tmce_pkg::res_t  res;
    logic            push, q_full, q_empty, q_pop, init_busy;

    // Hold the text attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_attribute_reg <= tmce_pkg::ATTR_RESET;
        else if (cfg_wr_en)
            text_attribute_reg <= cfg_wr_data;
    end

    tmce_front u_front (
        .start      (start),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tmce_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tmce_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .text_attribute (text_attribute_reg),
        .init_busy      (init_busy),
        .done           (done),
        .res            (res)
    );

    // Drive the result ports
    assign cursor_col      = res.cursor_col;
    assign cursor_row      = res.cursor_row;
    assign cursor_location = res.cursor_location;
    assign cell_written    = res.cell_written;
    assign write_index     = res.write_index;
    assign cell_data       = res.cell_data;
    assign scrolled        = res.scrolled;

endmodule

// ----- design/tmce_checker.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_mode_console_engine_macros.svh"

module tmce_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                clk,
    input logic                rst_n,
    input logic                done,
    input tmce_pkg::col_port_t cursor_col,
    input tmce_pkg::row_port_t cursor_row,
    input logic                cell_written,
    input tmce_pkg::cell_t     cell_data,
    input logic                scrolled
);

    // Every result needs a respond state, so strobes never run back to back
    `TMCE_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held two cycles")

    // Reported cursor stays on the screen
    `TMCE_ASSERT_NOW(a_cursor_range, clk, rst_n, done, (int'(cursor_col) < COLUMNS) && (int'(cursor_row) < ROWS), "cursor off screen")

    // A scroll leaves the cursor at the start of the bottom line
    `TMCE_ASSERT_NOW(a_scroll_home, clk, rst_n, done && scrolled, (cursor_col == '0) && (cursor_row == 5'(ROWS - 1)), "scroll left cursor misplaced")

    // Only printable bytes are stored
    `TMCE_ASSERT_NOW(a_printable, clk, rst_n, done && cell_written, (cell_data[7:0] >= 8'h20) && !cell_data[7], "non-printable byte stored")

endmodule

bind text_mode_console_engine tmce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (done),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .cell_written (cell_written),
    .cell_data    (cell_data),
    .scrolled     (scrolled)
);

// ----- sim/text_mode_console_engine_test.sv -----
// ----------------------------------------------------------------------------
// Text mode console engine testbench
// Sends put, clear and read items under several attribute settings and sender
// gap rates. Keeps a shadow screen and cursor to predict each cursor report
// and cell value, then checks every report field by field in arrival order.
// ----------------------------------------------------------------------------
module text_mode_console_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                  COLUMNS         = 80;
    localparam int                  ROWS            = 25;
    localparam int                  TAB_WIDTH       = 8;
    localparam int                  CELLS           = COLUMNS * ROWS;
    localparam tmce_pkg::op_t       OP_SPARE        = 2'd3;
    localparam tmce_pkg::char_t     CHAR_LAST_PRINT = 8'h7F;
    localparam tmce_pkg::idx_port_t INDEX_TOP       = 11'h7FF;
    localparam int                  CLOCK_HALF      = 10;
    localparam int                  RESET_CYCLES    = 5;
    localparam int                  SETTLE_CYCLES   = 20;
    localparam int                  CYCLE_LIMIT     = 10_000_000;
    localparam int                  RANDOM_ITEMS    = 550;
    localparam int                  PHASES          = 4;

    // Shadow screen and cursor, with the queue of reports still to arrive
    class console_scoreboard;
        tmce_pkg::cell_t screen [CELLS];
        int              col;
        int              row;
        tmce_pkg::attr_t attribute;
        tmce_pkg::res_t  awaited_reports [$];
        int              errors;

        function new();
            foreach (screen[i])
                screen[i] = tmce_pkg::BLANK_CELL;
            col       = 0;
            row       = 0;
            attribute = tmce_pkg::ATTR_RESET;
            errors    = 0;
        endfunction

        function void set_attribute(tmce_pkg::attr_t value);
            attribute = value;
        endfunction

        function int cursor_index();
            return row * COLUMNS + col;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // Apply one accepted item to the shadow console and queue its report
        function void note_command(tmce_pkg::op_t cmd_op, tmce_pkg::char_t ch,
                                   tmce_pkg::idx_port_t idx);
            tmce_pkg::res_t rep;
            int             i;
            rep = '0;
            if (cmd_op == tmce_pkg::OP_PUT)
            begin
                if (ch == tmce_pkg::CHAR_BS)
                begin
                    if (col > 0)
                        col--;
                end
                else if (ch == tmce_pkg::CHAR_TAB)
                begin
                    col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
                end
                else if (ch == tmce_pkg::CHAR_CR)
                begin
                    col = 0;
                end
                else if (ch == tmce_pkg::CHAR_LF)
                begin
                    col = 0;
                    row++;
                end
                else if (ch >= tmce_pkg::CHAR_SPACE && ch <= CHAR_LAST_PRINT)
                begin
                    rep.cell_written = 1'b1;
                    rep.write_index  = tmce_pkg::idx_port_t'(row * COLUMNS + col);
                    rep.cell_data    = {attribute, ch};
                    screen[row * COLUMNS + col] = {attribute, ch};
                    col++;
                end
                // wrap past the last column
                if (col >= COLUMNS)
                begin
                    col = 0;
                    row++;
                end
                // scroll up one row past the last line, blank the bottom row
                if (row >= ROWS)
                begin
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        screen[i] = screen[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        screen[i] = tmce_pkg::BLANK_CELL;
                    row          = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            else if (cmd_op == tmce_pkg::OP_CLEAR)
            begin
                foreach (screen[j])
                    screen[j] = tmce_pkg::BLANK_CELL;
                col = 0;
                row = 0;
            end
            else if (cmd_op == tmce_pkg::OP_READ)
            begin
                if (idx < CELLS)
                    rep.cell_data = screen[idx];
            end
            rep.cursor_col      = tmce_pkg::col_port_t'(col);
            rep.cursor_row      = tmce_pkg::row_port_t'(row);
            rep.cursor_location = tmce_pkg::idx_port_t'(row * COLUMNS + col);
            awaited_reports.push_back(rep);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Match a strobed report against the oldest one awaited
        function void check_report(tmce_pkg::res_t got);
            tmce_pkg::res_t want;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: report with none awaited, col %0d row %0d data %0h",
                         $time, got.cursor_col, got.cursor_row, got.cell_data);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare("cursor_col", want.cursor_col, got.cursor_col);
                compare("cursor_row", want.cursor_row, got.cursor_row);
                compare("cursor_location", want.cursor_location, got.cursor_location);
                compare("cell_written", want.cell_written, got.cell_written);
                compare("write_index", want.write_index, got.write_index);
                compare("cell_data", want.cell_data, got.cell_data);
                compare("scrolled", want.scrolled, got.scrolled);
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    tmce_pkg::op_t       op          = tmce_pkg::OP_PUT;
    tmce_pkg::char_t     char_code   = '0;
    tmce_pkg::idx_port_t cell_index  = '0;
    logic                cfg_wr_en   = 1'b0;
    tmce_pkg::attr_t     cfg_wr_data = tmce_pkg::ATTR_RESET;
    logic                done;
    tmce_pkg::col_port_t cursor_col;
    tmce_pkg::row_port_t cursor_row;
    tmce_pkg::idx_port_t cursor_location;
    logic                cell_written;
    tmce_pkg::idx_port_t write_index;
    tmce_pkg::cell_t     cell_data;
    logic                scrolled;

    console_scoreboard   board;
    int                  idle_pct        = 0;
    int                  effective_items = 0;
    int                  cycles          = 0;

    text_mode_console_engine u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .done            (done),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .cell_written    (cell_written),
        .write_index     (write_index),
        .cell_data       (cell_data),
        .scrolled        (scrolled)
    );

    initial
    begin
        forever #CLOCK_HALF clk = ~clk;
    end

    // Abandon the run if it stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("text_mode_console_engine_test: FAIL");
            $finish;
        end
    end

    // Check each report in the middle of its strobe cycle
    always @(negedge clk)
    begin : report_monitor
        tmce_pkg::res_t seen;
        if (rst_n && done === 1'b1)
        begin
            seen.cursor_col      = cursor_col;
            seen.cursor_row      = cursor_row;
            seen.cursor_location = cursor_location;
            seen.cell_written    = cell_written;
            seen.write_index     = write_index;
            seen.cell_data       = cell_data;
            seen.scrolled        = scrolled;
            board.check_report(seen);
        end
    end

    function automatic tmce_pkg::char_t any_printable();
        return tmce_pkg::char_t'($urandom_range(tmce_pkg::CHAR_SPACE, CHAR_LAST_PRINT));
    endfunction

    // Offer one item, hold it until taken, note it, then maybe pause the sender
    task automatic send_command(input tmce_pkg::op_t cmd_op, input tmce_pkg::char_t ch,
                                input tmce_pkg::idx_port_t idx);
        int gap;
        start      <= 1'b1;
        op         <= cmd_op;
        char_code  <= ch;
        cell_index <= idx;
        do
            @(negedge clk);
        while (busy !== 1'b0);
        board.note_command(cmd_op, ch, idx);
        // ignored bytes and the spare code do not count as real work
        if (!(cmd_op == OP_SPARE || (cmd_op == tmce_pkg::OP_PUT && (ch[7] ||
              (ch < tmce_pkg::CHAR_SPACE && ch != tmce_pkg::CHAR_BS &&
               ch != tmce_pkg::CHAR_TAB && ch != tmce_pkg::CHAR_LF &&
               ch != tmce_pkg::CHAR_CR)))))
            effective_items++;
        @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_char(input tmce_pkg::char_t ch);
        send_command(tmce_pkg::OP_PUT, ch, tmce_pkg::idx_port_t'($urandom_range(INDEX_TOP)));
    endtask

    task automatic read_cell(input tmce_pkg::idx_port_t idx);
        send_command(tmce_pkg::OP_READ, tmce_pkg::char_t'($urandom_range(255)), idx);
    endtask

    // Drop start and wait until every awaited report is in and the block is free
    task automatic wait_settled();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0 || busy !== 1'b0);
        @(posedge clk);
    endtask

    task automatic write_attribute(input tmce_pkg::attr_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_attribute(value);
    endtask

    // One burst of console traffic: mostly text, with control runs and reads
    task automatic random_burst();
        int kind;
        int len;
        int k;
        int here;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // line of text, some long enough to wrap, closed by a newline half the time
            len = ($urandom_range(3) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
            for (k = 0; k < len; k++)
                put_char(any_printable());
            case ($urandom_range(3))
                0: put_char(tmce_pkg::CHAR_LF);
                1:
                begin
                    put_char(tmce_pkg::CHAR_CR);
                    put_char(tmce_pkg::CHAR_LF);
                end
                default: ;
            endcase
        end
        else if (kind < 50)
        begin
            // tabs mixed with text, at times enough to run off the line end
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                put_char($urandom_range(1) ? tmce_pkg::CHAR_TAB : any_printable());
        end
        else if (kind < 58)
        begin
            // step back and overwrite
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
                put_char(tmce_pkg::CHAR_BS);
            if ($urandom_range(1))
                put_char(any_printable());
        end
        else if (kind < 64)
        begin
            // run of line feeds, at times down to and past the bottom row
            len = $urandom_range(1, 30);
            for (k = 0; k < len; k++)
                put_char(tmce_pkg::CHAR_LF);
        end
        else if (kind < 80)
        begin
            // read back cells, often just behind the cursor, else anywhere or out of range
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
            begin
                here = board.cursor_index();
                case ($urandom_range(9))
                    0: read_cell(tmce_pkg::idx_port_t'($urandom_range(CELLS, INDEX_TOP)));
                    1, 2, 3, 4:
                        read_cell(tmce_pkg::idx_port_t'((here >= COLUMNS) ?
                                  here - $urandom_range(1, COLUMNS) : here));
                    default: read_cell(tmce_pkg::idx_port_t'($urandom_range(CELLS - 1)));
                endcase
            end
        end
        else if (kind < 95)
        begin
            // noise: any code, any byte, any index
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
                send_command(tmce_pkg::op_t'($urandom_range(3)),
                             tmce_pkg::char_t'($urandom_range(255)),
                             tmce_pkg::idx_port_t'($urandom_range(INDEX_TOP)));
        end
        else
        begin
            send_command(tmce_pkg::OP_CLEAR, tmce_pkg::char_t'($urandom_range(255)),
                         tmce_pkg::idx_port_t'($urandom_range(INDEX_TOP)));
        end
    endtask

    // Main sequence: reset, directed items, then random phases
    initial
    begin
        int              phase;
        tmce_pkg::attr_t attr_pick;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, every code and each control byte at the reset attribute
        read_cell('0);
        read_cell(tmce_pkg::idx_port_t'(CELLS - 1));
        read_cell(tmce_pkg::idx_port_t'(CELLS));
        read_cell(INDEX_TOP);
        put_char(8'h41);
        put_char(tmce_pkg::CHAR_SPACE);
        put_char(CHAR_LAST_PRINT);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h1F);
        put_char(tmce_pkg::CHAR_BS);
        put_char(tmce_pkg::CHAR_TAB);
        put_char(tmce_pkg::CHAR_TAB);
        put_char(tmce_pkg::CHAR_CR);
        put_char(tmce_pkg::CHAR_BS);
        put_char(tmce_pkg::CHAR_LF);
        send_command(OP_SPARE, 8'h55, 11'h2AA);
        read_cell('0);
        read_cell(11'd2);
        send_command(tmce_pkg::OP_CLEAR, 8'hAA, 11'h555);
        read_cell('0);

        effective_items = 0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_settled();
            case (phase)
                0: attr_pick = 8'h00;
                1: attr_pick = 8'hFF;
                default: attr_pick = tmce_pkg::attr_t'($urandom_range(255));
            endcase
            write_attribute(attr_pick);
            case (phase)
                1: idle_pct = 48;
                3: idle_pct = 21;
                default: idle_pct = 0;
            endcase
            while (effective_items < (phase + 1) * RANDOM_ITEMS / PHASES)
                random_burst();
        end

        wait_settled();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("text_mode_console_engine_test: PASS");
        else
            $display("text_mode_console_engine_test: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/tmce_pkg.sv
design/tmce_front.sv
design/tmce_cmd_queue.sv
design/tmce_back.sv
design/text_mode_console_engine.sv
design/tmce_checker.sv
sim/text_mode_console_engine_test.sv
